// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the congestion window controller
// Beat layouts, event kinds, window modes, config indexes, window saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    // field widths
    localparam int SEQ_W      = 31;
    localparam int WIN_W      = 16;

    // segment size is a power of two: byte offsets divide by a shift
    localparam int SEG_SHIFT  = 10;
    localparam int SEG_BYTES  = 1 << SEG_SHIFT;
    localparam int WINDOW_MAX = 65535;

    // whole segments in a byte span, and the avoidance sum accum + n
    localparam int N_W        = SEQ_W - SEG_SHIFT;
    localparam int TOT_W      = ((N_W > WIN_W) ? N_W : WIN_W) + 1;
    // segments left to the end of the transfer (rounded up)
    localparam int SPAN_W     = SEQ_W + 1 - SEG_SHIFT;

    localparam int INIT_THRESH_RST = 64;
    localparam int FR_INFLATE      = 3;
    localparam logic [1:0] DUP_THRESH = 2'd3;

    localparam int CMD_Q_DEPTH_DEF = 4;
    localparam int RES_Q_DEPTH_DEF = 4;

    // input command codes
    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_ACK     = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    // reported mode codes
    localparam logic [1:0] MODE_SS = 2'd0;
    localparam logic [1:0] MODE_CA = 2'd1;
    localparam logic [1:0] MODE_FR = 2'd2;

    // config register indexes
    localparam logic CFG_TOTAL_BYTES = 1'b0;
    localparam logic CFG_INIT_THRESH = 1'b1;

    typedef enum logic [2:0] {
        M_SS = 3'b001,
        M_CA = 3'b010,
        M_FR = 3'b100
    } t_mode;

    // event kind as classified by the front end
    typedef enum logic [2:0] {
        K_IGNORE  = 3'd0,
        K_START   = 3'd1,
        K_TIMEOUT = 3'd2,
        K_NEW_ACK = 3'd3,
        K_DUP_ACK = 3'd4,
        K_OLD_ACK = 3'd5
    } t_kind;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [SEQ_W-1:0] ack_number;
    } t_in_beat;

    typedef struct packed {
        logic [SEQ_W-1:0] send_first_seq;
        logic [WIN_W-1:0] send_count;
        logic             retransmit;
        logic [SEQ_W-1:0] retransmit_seq;
        logic [WIN_W-1:0] window;
        logic [WIN_W-1:0] threshold;
        logic [1:0]       mode;
        logic             done_res;
    } t_out_beat;

    // classified event, front -> back
    typedef struct packed {
        t_kind            kind;
        logic [N_W-1:0]   n;      // newly acked segments
        logic [SEQ_W-1:0] base;   // acked base after the event
        logic             fin;    // finished after the event
    } t_cmd_item;

    typedef struct packed {
        logic             vld;
        logic             idx;
        logic [SEQ_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic             start;
        logic             clear;
        logic [TOT_W-1:0] dividend;
        logic [WIN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             idle;
        logic             done;
        logic [TOT_W-1:0] quot;
        logic [WIN_W-1:0] rem;
    } t_div_rsp;

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        unique case (m)
            M_SS:    c = MODE_SS;
            M_CA:    c = MODE_CA;
            M_FR:    c = MODE_FR;
            default: c = MODE_SS;
        endcase
        return c;
    endfunction

    function automatic logic [WIN_W-1:0] sat_win(input logic [TOT_W:0] v);
        logic [WIN_W-1:0] r;
        if (v > (TOT_W+1)'(WINDOW_MAX)) begin
            r = WIN_W'(WINDOW_MAX);
        end else begin
            r = v[WIN_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tcp_congestion_window_control.sv =====
// ----------------------------------------------------------------------------
// tcp_congestion_window_control: Reno sender congestion window controller
// Throughput: 1 event/cycle while the result queue has room and no division runs;
// an avoidance ack whose backlog reaches two windows waits in the divider.
// Reset: synchronous, active low; control state and valid flags cleared at once, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_congestion_window_control import tcw_pkg::*; #(
    parameter int CMD_Q_DEPTH = CMD_Q_DEPTH_DEF,
    parameter int RES_Q_DEPTH = RES_Q_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // event input queue side
    input  wire logic             push,
    output logic                  full,
    input  wire t_in_beat         i_in_beat,
    // result queue side
    output logic                  empty,
    input  wire logic             pop,
    output t_out_beat             o_out_beat,
    // config write channel
    input  wire logic             valid,
    output logic                  ready,
    input  wire logic             i_cfg_index,
    input  wire logic [SEQ_W-1:0] i_cfg_data
);

    // Front end: classifies each event against the acked base as it is
    // accepted and queues it. Back end: window engine (S1), transfer-end
    // bound (S2), trim against last sent and emit (S3) into the result queue.

    t_cfg_wr   cfg;
    t_cmd_item fe_item, q_item;
    logic [$bits(t_cmd_item)-1:0] q_data;
    logic [$bits(t_out_beat)-1:0] res_data;
    logic      accept, q_empty, q_pop;
    logic      res_full, res_push;
    t_out_beat res_beat;
    t_div_req  div_req;
    t_div_rsp  div_rsp;
    logic [SEQ_W-1:0] total_bytes;

    // config is taken every cycle; the user must write only while idle, the block does not enforce it
    assign ready    = 1'b1;
    assign cfg.vld  = valid;
    assign cfg.idx  = i_cfg_index;
    assign cfg.data = i_cfg_data;

    // an event beat is taken whenever the command queue has room
    assign accept = push && !full;

    tcw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_in_beat     (i_in_beat),
        .i_cfg         (cfg),
        .o_item        (fe_item),
        .o_total_bytes (total_bytes)
    );

    // decouples classification from the window engine
    tcw_fifo #(
        .W     ($bits(t_cmd_item)),
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (fe_item),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    assign q_item = t_cmd_item'(q_data);

    tcw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_total_bytes (total_bytes),
        .i_item_vld    (!q_empty),
        .i_item        (q_item),
        .o_item_pop    (q_pop),
        .o_div_req     (div_req),
        .i_div_rsp     (div_rsp),
        .i_res_full    (res_full),
        .o_res_push    (res_push),
        .o_res         (res_beat)
    );

    // accumulator / window division for large avoidance acks
    tcw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // result queue: the back end keeps running while results wait to be popped, until the queue is full
    tcw_fifo #(
        .W     ($bits(t_out_beat)),
        .DEPTH (RES_Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_beat),
        .o_full  (res_full),
        .i_pop   (pop && !empty),
        .o_data  (res_data),
        .o_empty (empty)
    );

    assign o_out_beat = t_out_beat'(res_data);

endmodule

`default_nettype wire

// ===== rtl/tcw_fifo.sv =====
// ----------------------------------------------------------------------------
// tcw_fifo: small first-word-fall-through queue
// Head visible while not empty; user must not push when full; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_fifo import tcw_pkg::*; #(
    parameter int W     = $bits(t_out_beat),
    parameter int DEPTH = RES_Q_DEPTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("tcw_fifo: push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("tcw_fifo: pop while empty");
`endif

endmodule

`default_nettype wire

// ===== rtl/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front: event intake and classification
// Owns acked base, finished flag and the total-bytes register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front import tcw_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_beat i_in_beat,
    input  wire t_cfg_wr  i_cfg,
    output t_cmd_item     o_item,
    output logic [SEQ_W-1:0] o_total_bytes
);

    logic [SEQ_W-1:0] r_base, n_base, r_total, diff;
    logic             r_fin, n_fin, fin_now, ack_new, ack_dup;
    t_kind            kind;

    always_comb begin
        fin_now = r_fin | (r_base >= r_total);
        ack_new = i_in_beat.ack_number > r_base;
        ack_dup = i_in_beat.ack_number == r_base;
        diff    = i_in_beat.ack_number - r_base;
        n_base  = r_base;
        n_fin   = fin_now;
        kind    = K_IGNORE;
        if (!fin_now) begin
            unique case (i_in_beat.cmd)
                CMD_START:   kind = K_START;
                CMD_TIMEOUT: kind = K_TIMEOUT;
                CMD_ACK: begin
                    priority if (ack_new) begin
                        kind   = K_NEW_ACK;
                        n_base = i_in_beat.ack_number;
                        n_fin  = i_in_beat.ack_number >= r_total;
                    end else if (ack_dup) begin
                        kind = K_DUP_ACK;
                    end else begin
                        kind = K_OLD_ACK;
                    end
                end
                default:     kind = K_IGNORE;
            endcase
        end
    end

    assign o_item.kind    = kind;
    assign o_item.n       = diff[SEQ_W-1:SEG_SHIFT];
    assign o_item.base    = n_base;
    assign o_item.fin     = n_fin;
    assign o_total_bytes  = r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_fin   <= 1'b0;
            r_total <= '0;
        end else begin
            if (i_accept) begin
                r_base <= n_base;
                r_fin  <= n_fin;
            end
            if (i_cfg.vld && i_cfg.idx == CFG_TOTAL_BYTES) begin
                r_total <= i_cfg.data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tcw_div.sv =====
// ----------------------------------------------------------------------------
// tcw_div: radix-2 restoring divider for the avoidance accumulator
// One quotient bit per cycle; result held until cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_div import tcw_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(TOT_W);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_BUSY = 3'b010,
        D_DONE = 3'b100
    } t_dstate;

    t_dstate          r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [TOT_W-1:0] r_quo;
    logic [WIN_W-1:0] r_rem, r_dvs, rem_nx;
    logic [WIN_W:0]   shifted, trial;
    logic             ge;

    always_comb begin
        shifted = {r_rem, r_quo[TOT_W-1]};
        trial   = shifted - {1'b0, r_dvs};
        ge      = !trial[WIN_W];
        rem_nx  = ge ? trial[WIN_W-1:0] : shifted[WIN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        r_state <= D_BUSY;
                        r_cnt   <= CNT_W'(TOT_W - 1);
                    end
                end
                D_BUSY: begin
                    if (r_cnt == '0) begin
                        r_state <= D_DONE;
                    end
                    r_cnt <= r_cnt - 1'b1;
                end
                D_DONE: begin
                    if (i_req.clear) begin
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE && i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_state == D_BUSY) begin
            r_quo <= {r_quo[TOT_W-2:0], ge};
            r_rem <= rem_nx;
        end
    end

    assign o_rsp.idle = (r_state == D_IDLE);
    assign o_rsp.done = (r_state == D_DONE);
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (r_state == D_IDLE))
        else $error("tcw_div: start while busy");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == D_DONE) |-> (r_rem < r_dvs))
        else $error("tcw_div: remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ===== rtl/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw_back: window engine and send planner
// S1 updates window state, S2 bounds the run by the transfer end,
// S3 trims it against the last segment sent and emits the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back import tcw_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg_wr          i_cfg,
    input  wire logic [SEQ_W-1:0] i_total_bytes,
    input  wire logic             i_item_vld,
    input  wire t_cmd_item        i_item,
    output logic                  o_item_pop,
    output t_div_req              o_div_req,
    input  wire t_div_rsp         i_div_rsp,
    input  wire logic             i_res_full,
    output logic                  o_res_push,
    output t_out_beat             o_res
);

    typedef struct packed {
        logic             send;
        logic             rex;
        logic [SEQ_W-1:0] base;
        logic [WIN_W-1:0] cwnd;
        logic [WIN_W-1:0] ssth;
        logic [1:0]       mode;
        logic             fin;
    } t_ev;

    typedef struct packed {
        t_ev              ev;
        logic [WIN_W-1:0] hi;
    } t_plan;

    // ---- S1: window state ----
    t_mode            r_mode, n_mode, eff_mode;
    logic [WIN_W-1:0] r_cwnd, n_cwnd, r_ssth, n_ssth, r_accum, n_accum, w;
    logic [1:0]       r_dup, n_dup, dup_inc;
    logic [TOT_W-1:0] tot, tot_ex;
    logic [WIN_W-1:0] cwnd_inc, cwnd_add_n, cwnd_add_q, fr_cwnd;
    logic             fast0, fast1, acts, need_div, s1_go, ev_send, ev_rex;

    // ---- pipeline ----
    t_ev              r_s2;
    t_plan            r_s3;
    logic             r_s2_vld, r_s3_vld, s2_adv, s2_free, s3_free;

    // ---- S2 / S3 ----
    logic [SEQ_W:0]   span_raw;
    logic [SPAN_W-1:0] span, lo;
    logic [WIN_W-1:0] hi, hi_m1, cnt;
    logic [SEQ_W-1:0] r_last, diff, first, top;
    logic             r_ls_vld, ls_ge, snd;

    always_comb begin
        w        = (r_cwnd == '0) ? WIN_W'(1) : r_cwnd;
        tot      = TOT_W'(r_accum) + TOT_W'(i_item.n);
        tot_ex   = tot - TOT_W'(w);
        fast0    = tot < TOT_W'(w);
        fast1    = tot_ex < TOT_W'(w);
        dup_inc  = r_dup + 2'd1;

        cwnd_inc   = sat_win((TOT_W+1)'(r_cwnd) + (TOT_W+1)'(1));
        cwnd_add_n = sat_win((TOT_W+1)'(r_cwnd) + (TOT_W+1)'(i_item.n));
        cwnd_add_q = sat_win((TOT_W+1)'(r_cwnd) + (TOT_W+1)'(i_div_rsp.quot));
        fr_cwnd    = sat_win((TOT_W+1)'(r_cwnd >> 1) + (TOT_W+1)'(FR_INFLATE));

        acts = (i_item.kind == K_TIMEOUT) || (i_item.kind == K_NEW_ACK) ||
               (i_item.kind == K_DUP_ACK) || (i_item.kind == K_OLD_ACK);
        // slow start hands over to avoidance ahead of any ack or timeout
        eff_mode = (acts && r_mode == M_SS && r_cwnd >= r_ssth) ? M_CA : r_mode;

        need_div = i_item_vld && (i_item.kind == K_NEW_ACK) && (eff_mode == M_CA) &&
                   !fast0 && !fast1;

        n_mode  = r_mode;
        n_cwnd  = r_cwnd;
        n_ssth  = r_ssth;
        n_accum = r_accum;
        n_dup   = r_dup;
        ev_send = 1'b0;
        ev_rex  = 1'b0;

        unique case (i_item.kind)
            K_START: begin
                ev_send = 1'b1;
            end
            K_TIMEOUT: begin
                n_ssth  = r_cwnd >> 1;
                n_cwnd  = WIN_W'(1);
                n_accum = '0;
                n_dup   = '0;
                n_mode  = M_SS;
                ev_rex  = 1'b1;
            end
            K_NEW_ACK: begin
                n_dup  = '0;
                n_mode = eff_mode;
                unique case (eff_mode)
                    M_SS: n_cwnd = cwnd_add_n;
                    M_CA: begin
                        // one window increment per full window of acked segments
                        priority if (fast0) begin
                            n_accum = tot[WIN_W-1:0];
                        end else if (fast1) begin
                            n_accum = tot_ex[WIN_W-1:0];
                            n_cwnd  = cwnd_inc;
                        end else begin
                            n_accum = i_div_rsp.rem;
                            n_cwnd  = cwnd_add_q;
                        end
                    end
                    M_FR: begin
                        n_cwnd  = (r_ssth == '0) ? WIN_W'(1) : r_ssth;
                        n_accum = '0;
                        n_mode  = M_CA;
                    end
                    default: n_mode = eff_mode;
                endcase
                ev_send = !i_item.fin;
            end
            K_DUP_ACK: begin
                n_mode = eff_mode;
                if (eff_mode == M_FR) begin
                    n_cwnd  = cwnd_inc;
                    ev_send = 1'b1;
                end else begin
                    n_dup = dup_inc;
                    if (dup_inc == DUP_THRESH) begin
                        // fast retransmit of the base, enter recovery
                        n_ssth  = r_cwnd >> 1;
                        n_cwnd  = fr_cwnd;
                        n_accum = '0;
                        n_mode  = M_FR;
                        ev_rex  = 1'b1;
                    end
                end
            end
            K_OLD_ACK: begin
                n_mode = eff_mode;
            end
            K_IGNORE: begin
                n_mode = r_mode;
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    // handshakes through the three stages
    always_comb begin
        s3_free    = !r_s3_vld || !i_res_full;
        o_res_push = r_s3_vld && !i_res_full;
        s2_adv     = r_s2_vld && s3_free;
        s2_free    = !r_s2_vld || s2_adv;
        s1_go      = i_item_vld && s2_free && (!need_div || i_div_rsp.done);
    end

    assign o_item_pop         = s1_go;
    assign o_div_req.start    = need_div && i_div_rsp.idle;
    assign o_div_req.clear    = s1_go && need_div;
    assign o_div_req.dividend = tot;
    assign o_div_req.divisor  = w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_SS;
            r_cwnd   <= WIN_W'(1);
            r_ssth   <= WIN_W'(INIT_THRESH_RST);
            r_accum  <= '0;
            r_dup    <= '0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_ls_vld <= 1'b0;
        end else begin
            if (s1_go) begin
                r_mode  <= n_mode;
                r_cwnd  <= n_cwnd;
                r_ssth  <= n_ssth;
                r_accum <= n_accum;
                r_dup   <= n_dup;
            end else if (i_cfg.vld && i_cfg.idx == CFG_INIT_THRESH) begin
                r_ssth <= i_cfg.data[WIN_W-1:0];
            end
            if (s1_go) begin
                r_s2_vld <= 1'b1;
            end else if (s2_adv) begin
                r_s2_vld <= 1'b0;
            end
            if (s2_adv) begin
                r_s3_vld <= 1'b1;
            end else if (o_res_push) begin
                r_s3_vld <= 1'b0;
            end
            if (o_res_push && snd) begin
                r_ls_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s2.send <= ev_send;
            r_s2.rex  <= ev_rex;
            r_s2.base <= i_item.base;
            r_s2.cwnd <= n_cwnd;
            r_s2.ssth <= n_ssth;
            r_s2.mode <= mode_code(n_mode);
            r_s2.fin  <= i_item.fin;
        end
        if (s2_adv) begin
            r_s3.ev <= r_s2;
            r_s3.hi <= hi;
        end
        if (o_res_push && snd) begin
            r_last <= top;
        end
    end

    // S2: segments that fit before the end of the transfer, capped by the window
    always_comb begin
        span_raw = {1'b0, i_total_bytes} - {1'b0, r_s2.base} +
                   (SEQ_W+1)'(SEG_BYTES - 1);
        span     = span_raw[SEQ_W:SEG_SHIFT];
        if (!r_s2.send || r_s2.base >= i_total_bytes) begin
            hi = '0;
        end else if (span < SPAN_W'(r_s2.cwnd)) begin
            hi = WIN_W'(span);
        end else begin
            hi = r_s2.cwnd;
        end
    end

    // S3: skip segments already sent
    always_comb begin
        ls_ge = r_ls_vld && (r_last >= r_s3.ev.base);
        diff  = r_last - r_s3.ev.base;
        lo    = ls_ge ? (SPAN_W'(diff[SEQ_W-1:SEG_SHIFT]) + SPAN_W'(1)) : '0;
        snd   = SPAN_W'(r_s3.hi) > lo;
        hi_m1 = r_s3.hi - WIN_W'(1);
        first = r_s3.ev.base + SEQ_W'({lo, {SEG_SHIFT{1'b0}}});
        top   = r_s3.ev.base + SEQ_W'({hi_m1, {SEG_SHIFT{1'b0}}});
        cnt   = r_s3.hi - WIN_W'(lo);

        o_res.send_first_seq = snd ? first : '0;
        o_res.send_count     = snd ? cnt : '0;
        o_res.retransmit     = r_s3.ev.rex;
        o_res.retransmit_seq = r_s3.ev.rex ? r_s3.ev.base : '0;
        o_res.window         = r_s3.ev.cwnd;
        o_res.threshold      = r_s3.ev.ssth;
        o_res.mode           = r_s3.ev.mode;
        o_res.done_res       = r_s3.ev.fin;
    end

`ifndef SYNTHESIS
    a_fr_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_FR) == (r_dup == DUP_THRESH))
        else $error("tcw_back: recovery mode and duplicate count disagree");
    a_cwnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cwnd != '0) && (32'(r_cwnd) <= 32'(WINDOW_MAX)))
        else $error("tcw_back: window out of range");
`endif

endmodule

`default_nettype wire
